/* sv/cpu_instruction_length_decoder_top_assert.svh */
// Assertion macros for the instruction length decoder.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef CPU_INSTRUCTION_LENGTH_DECODER_TOP_ASSERT_SVH
`define CPU_INSTRUCTION_LENGTH_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CILD_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CILD_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cild_pkg.sv */
// Shared types and constants for the instruction length decoder.
// No dependencies; used by the interfaces and all modules.
package cild_pkg;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [7:0] PFX_CB = 8'hCB;
    localparam logic [7:0] PFX_ED = 8'hED;
    localparam logic [7:0] PFX_DD = 8'hDD;
    localparam logic [7:0] PFX_FD = 8'hFD;

    localparam logic [2:0] GRP_NONE = 3'd0;
    localparam logic [2:0] GRP_CB   = 3'd1;
    localparam logic [2:0] GRP_ED   = 3'd2;
    localparam logic [2:0] GRP_DD   = 3'd3;
    localparam logic [2:0] GRP_FD   = 3'd4;
    localparam logic [2:0] GRP_DDCB = 3'd5;
    localparam logic [2:0] GRP_FDCB = 3'd6;

    localparam logic [1:0] IMM_NONE = 2'd0;
    localparam logic [1:0] IMM_BYTE = 2'd1;
    localparam logic [1:0] IMM_WORD = 2'd2;

    localparam logic [1:0] IDX_NONE = 2'd0;
    localparam logic [1:0] IDX_IX   = 2'd1;
    localparam logic [1:0] IDX_IY   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]        start_address;
        logic [7:0]               length;
        logic [2:0]               prefix_group;
        logic [BYTE_W-1:0]        opcode;
        logic signed [BYTE_W-1:0] displacement;
        logic                     has_displacement;
        logic [15:0]              immediate;
        logic [1:0]               immediate_kind;
        logic [ADDR_W-1:0]        branch_target;
        logic                     is_relative;
        logic                     undefined_ed;
    } desc_t;

endpackage

/* sv/cild_if.sv */
// Request channels of the instruction length decoder: byte stream and descriptors.
// Depends on cild_pkg.
interface cild_byte_if;
    logic                        valid;
    logic                        ready;
    logic [cild_pkg::BYTE_W-1:0] byte_value;
    logic [cild_pkg::ADDR_W-1:0] byte_address;

    modport source (output valid, output byte_value, output byte_address, input ready);
    modport sink (input valid, input byte_value, input byte_address, output ready);
endinterface

interface cild_desc_if;
    logic                               valid;
    logic                               ready;
    logic [cild_pkg::ADDR_W-1:0]        start_address;
    logic [7:0]                         length;
    logic [2:0]                         prefix_group;
    logic [cild_pkg::BYTE_W-1:0]        opcode;
    logic signed [cild_pkg::BYTE_W-1:0] displacement;
    logic                               has_displacement;
    logic [15:0]                        immediate;
    logic [1:0]                         immediate_kind;
    logic [cild_pkg::ADDR_W-1:0]        branch_target;
    logic                               is_relative;
    logic                               undefined_ed;

    modport source (
        output valid, output start_address, output length, output prefix_group,
        output opcode, output displacement, output has_displacement,
        output immediate, output immediate_kind, output branch_target,
        output is_relative, output undefined_ed, input ready
    );
    modport sink (
        input valid, input start_address, input length, input prefix_group,
        input opcode, input displacement, input has_displacement,
        input immediate, input immediate_kind, input branch_target,
        input is_relative, input undefined_ed, output ready
    );
endinterface

/* sv/cild_in_stage.sv */
// Input register of the decoder: captures one byte request and holds it until decoded.
// Depends on cild_pkg and cild_byte_if.
module cild_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    cild_byte_if.sink                   instr_bytes,
    input  logic                        advance,
    output logic                        stage_valid,
    output logic [cild_pkg::BYTE_W-1:0] stage_byte,
    output logic [cild_pkg::ADDR_W-1:0] stage_addr
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [cild_pkg::BYTE_W-1:0] byte_reg;
    logic [cild_pkg::ADDR_W-1:0] addr_reg;
    logic                        take;

    assign instr_bytes.ready = !valid_reg || advance;
    assign take              = instr_bytes.valid && instr_bytes.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= instr_bytes.byte_value;
            addr_reg <= instr_bytes.byte_address;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;
    assign stage_addr  = addr_reg;

endmodule

/* sv/cild_step.sv */
// Decode state machine: follows prefixes and operands one byte per cycle while fire is high.
// Depends on cild_pkg; produces one descriptor when an instruction ends.
module cild_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [cild_pkg::BYTE_W-1:0] byte_value,
    input  logic [cild_pkg::ADDR_W-1:0] byte_address,
    output logic                        emit,
    output cild_pkg::desc_t             result
);

    localparam logic [2:0] PH_OPCODE   = 3'd0;
    localparam logic [2:0] PH_INDEXED  = 3'd1;
    localparam logic [2:0] PH_CB       = 3'd2;
    localparam logic [2:0] PH_ED       = 3'd3;
    localparam logic [2:0] PH_XCB_DISP = 3'd4;
    localparam logic [2:0] PH_XCB_OP   = 3'd5;
    localparam logic [2:0] PH_OPERANDS = 3'd6;

    localparam int FL_DISP    = 0;
    localparam int FL_REL     = 1;
    localparam int FL_UNDEF   = 2;
    localparam int FL_PENDING = 3;

    logic [2:0]                  phase_reg, phase_next;
    logic [1:0]                  index_reg, index_next;
    logic [7:0]                  count_reg, count_next;
    logic [1:0]                  left_reg, left_next;
    logic [cild_pkg::ADDR_W-1:0] first_reg, first_next;
    logic [7:0]                  opcode_reg, opcode_next;
    logic [2:0]                  group_reg, group_next;
    logic [7:0]                  disp_reg, disp_next;
    logic [15:0]                 imm_reg, imm_next;
    logic [3:0]                  flags_reg, flags_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [cild_pkg::ADDR_W-1:0] target_reg, target_next;

    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    logic       idx;
    logic       m_need_disp;
    logic       m_rel;
    logic [1:0] m_imm;
    logic       ed_defined;
    logic       do_emit;

    assign x   = byte_value[7:6];
    assign y   = byte_value[5:3];
    assign z   = byte_value[2:0];
    assign p   = y[2:1];
    assign q   = y[0];
    assign idx = index_reg != cild_pkg::IDX_NONE;

    always_comb
    begin
        m_need_disp = 1'b0;
        m_rel       = 1'b0;
        m_imm       = cild_pkg::IMM_NONE;
        unique case (x)
            2'd0:
            begin
                if (z == 3'd0 && y >= 3'd2)
                begin
                    m_rel = 1'b1;
                end
                else if (z == 3'd1 && !q)
                begin
                    m_imm = cild_pkg::IMM_WORD;
                end
                else if (z == 3'd2 && p >= 2'd2)
                begin
                    m_imm = cild_pkg::IMM_WORD;
                end
                else if (z == 3'd6)
                begin
                    m_imm = cild_pkg::IMM_BYTE;
                end
                m_need_disp = idx && y == 3'd6 && (z == 3'd4 || z == 3'd5 || z == 3'd6);
            end
            2'd1:
            begin
                m_need_disp = idx && byte_value != 8'h76 && (y == 3'd6 || z == 3'd6);
            end
            2'd2:
            begin
                m_need_disp = idx && z == 3'd6;
            end
            default:
            begin
                if (z == 3'd2 || z == 3'd4)
                begin
                    m_imm = cild_pkg::IMM_WORD;
                end
                else if (z == 3'd3 && y == 3'd0)
                begin
                    m_imm = cild_pkg::IMM_WORD;
                end
                else if (z == 3'd3 && (y == 3'd2 || y == 3'd3))
                begin
                    m_imm = cild_pkg::IMM_BYTE;
                end
                else if (z == 3'd5 && q && p == 2'd0)
                begin
                    m_imm = cild_pkg::IMM_WORD;
                end
                else if (z == 3'd6)
                begin
                    m_imm = cild_pkg::IMM_BYTE;
                end
            end
        endcase
    end

    assign ed_defined = (x == 2'd1) || (x == 2'd2 && z <= 3'd3 && y >= 3'd4);

    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        first_next  = first_reg;
        opcode_next = opcode_reg;
        group_next  = group_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        flags_next  = flags_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        do_emit     = 1'b0;
        result      = '0;

        if (fire)
        begin
            if (phase_reg == PH_OPCODE)
            begin
                first_next = byte_address;
            end
            if (count_reg != 8'hFF)
            begin
                count_next = count_reg + 8'd1;
            end

            unique case (phase_reg)
                PH_OPCODE, PH_INDEXED:
                begin
                    if (byte_value == cild_pkg::PFX_DD)
                    begin
                        index_next = cild_pkg::IDX_IX;
                        phase_next = PH_INDEXED;
                    end
                    else if (byte_value == cild_pkg::PFX_FD)
                    begin
                        index_next = cild_pkg::IDX_IY;
                        phase_next = PH_INDEXED;
                    end
                    else if (byte_value == cild_pkg::PFX_ED)
                    begin
                        index_next = cild_pkg::IDX_NONE;
                        phase_next = PH_ED;
                    end
                    else if (byte_value == cild_pkg::PFX_CB)
                    begin
                        phase_next = idx ? PH_XCB_DISP : PH_CB;
                    end
                    else
                    begin
                        opcode_next = byte_value;
                        if (!idx)
                        begin
                            group_next = cild_pkg::GRP_NONE;
                        end
                        else if (index_reg == cild_pkg::IDX_IX)
                        begin
                            group_next = cild_pkg::GRP_DD;
                        end
                        else
                        begin
                            group_next = cild_pkg::GRP_FD;
                        end
                        kind_next = m_imm;
                        left_next = m_imm;
                        if (m_need_disp || m_rel)
                        begin
                            flags_next[FL_DISP]    = 1'b1;
                            flags_next[FL_PENDING] = 1'b1;
                        end
                        if (m_rel)
                        begin
                            flags_next[FL_REL] = 1'b1;
                        end
                        if (flags_next[FL_PENDING] || m_imm != cild_pkg::IMM_NONE)
                        begin
                            phase_next = PH_OPERANDS;
                        end
                        else
                        begin
                            do_emit = 1'b1;
                        end
                    end
                end
                PH_CB:
                begin
                    opcode_next = byte_value;
                    group_next  = cild_pkg::GRP_CB;
                    do_emit     = 1'b1;
                end
                PH_ED:
                begin
                    opcode_next = byte_value;
                    group_next  = cild_pkg::GRP_ED;
                    if (x == 2'd1 && z == 3'd3)
                    begin
                        kind_next  = cild_pkg::IMM_WORD;
                        left_next  = cild_pkg::IMM_WORD;
                        phase_next = PH_OPERANDS;
                    end
                    else
                    begin
                        if (!ed_defined)
                        begin
                            flags_next[FL_UNDEF] = 1'b1;
                        end
                        do_emit = 1'b1;
                    end
                end
                PH_XCB_DISP:
                begin
                    disp_next          = byte_value;
                    flags_next[FL_DISP] = 1'b1;
                    phase_next         = PH_XCB_OP;
                end
                PH_XCB_OP:
                begin
                    opcode_next = byte_value;
                    group_next  = (index_reg == cild_pkg::IDX_IX) ? cild_pkg::GRP_DDCB
                                                                  : cild_pkg::GRP_FDCB;
                    do_emit     = 1'b1;
                end
                PH_OPERANDS:
                begin
                    if (flags_reg[FL_PENDING])
                    begin
                        disp_next              = byte_value;
                        flags_next[FL_PENDING] = 1'b0;
                        target_next = byte_address + 16'd1
                                      + {{8{byte_value[7]}}, byte_value};
                    end
                    else if (left_reg != 2'd0)
                    begin
                        if (left_reg == kind_reg)
                        begin
                            imm_next = {8'h00, byte_value};
                        end
                        else
                        begin
                            imm_next = {byte_value, imm_reg[7:0]};
                        end
                        left_next = left_reg - 2'd1;
                    end
                    if (!flags_next[FL_PENDING] && left_next == 2'd0)
                    begin
                        do_emit = 1'b1;
                    end
                end
                default:
                begin
                    phase_next  = PH_OPCODE;
                    index_next  = cild_pkg::IDX_NONE;
                    count_next  = 8'd0;
                    left_next   = 2'd0;
                    opcode_next = 8'd0;
                    group_next  = cild_pkg::GRP_NONE;
                    disp_next   = 8'd0;
                    imm_next    = 16'd0;
                    flags_next  = 4'd0;
                    kind_next   = cild_pkg::IMM_NONE;
                    target_next = 16'd0;
                end
            endcase

            if (do_emit)
            begin
                result.start_address    = first_next;
                result.length           = count_next;
                result.prefix_group     = group_next;
                result.opcode           = opcode_next;
                result.displacement     = flags_next[FL_DISP] ? disp_next : 8'd0;
                result.has_displacement = flags_next[FL_DISP];
                result.immediate        = imm_next;
                result.immediate_kind   = kind_next;
                result.branch_target    = flags_next[FL_REL] ? target_next : 16'd0;
                result.is_relative      = flags_next[FL_REL];
                result.undefined_ed     = flags_next[FL_UNDEF];

                phase_next  = PH_OPCODE;
                index_next  = cild_pkg::IDX_NONE;
                count_next  = 8'd0;
                left_next   = 2'd0;
                opcode_next = 8'd0;
                group_next  = cild_pkg::GRP_NONE;
                disp_next   = 8'd0;
                imm_next    = 16'd0;
                flags_next  = 4'd0;
                kind_next   = cild_pkg::IMM_NONE;
                target_next = 16'd0;
            end
        end
    end

    assign emit = do_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            index_reg  <= cild_pkg::IDX_NONE;
            count_reg  <= 8'd0;
            left_reg   <= 2'd0;
            first_reg  <= '0;
            opcode_reg <= 8'd0;
            group_reg  <= cild_pkg::GRP_NONE;
            disp_reg   <= 8'd0;
            imm_reg    <= 16'd0;
            flags_reg  <= 4'd0;
            kind_reg   <= cild_pkg::IMM_NONE;
            target_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            first_reg  <= first_next;
            opcode_reg <= opcode_next;
            group_reg  <= group_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
            flags_reg  <= flags_next;
            kind_reg   <= kind_next;
            target_reg <= target_next;
        end
    end

endmodule

/* sv/cpu_instruction_length_decoder_top.sv */
// Top level of the instruction length decoder: input register, decode step, result register.
// Depends on cild_pkg, cild_if, cild_in_stage, cild_step and the assertion macro header.
//
// The block takes instruction bytes on instr_bytes, one request per byte, each with
// the address it was fetched from. After the last byte of an instruction it offers
// one descriptor request on descriptors: start address, length, prefix group, final
// opcode, displacement, immediate, relative branch target and an undefined-ED flag.
// Prefix bytes and operand bytes that do not end an instruction produce no descriptor.
// A byte is taken into an input register, decoded against the decode state once the
// result register is free or being read, and the descriptor lands in the result
// register, from which it is offered on descriptors.
// One byte is accepted every cycle; the decode step and the result register keep
// that rate as long as descriptors are taken.
// When the receiver stalls, the descriptor waits in the result register and the
// input register still takes one more byte if it is empty; further bytes wait until the
// result register frees up.
// Reset clears the decode state so that the next byte starts a new instruction.
`include "cpu_instruction_length_decoder_top_assert.svh"

module cpu_instruction_length_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    cild_byte_if.sink   instr_bytes,
    cild_desc_if.source descriptors
);

    logic                        advance;
    logic                        stage_valid;
    logic [cild_pkg::BYTE_W-1:0] stage_byte;
    logic [cild_pkg::ADDR_W-1:0] stage_addr;
    logic                        fire;
    logic                        emit;
    cild_pkg::desc_t             result;
    cild_pkg::desc_t             desc_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    assign advance = !out_valid_reg || descriptors.ready;
    assign fire    = stage_valid && advance;

    cild_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_bytes (instr_bytes),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte),
        .stage_addr  (stage_addr)
    );

    cild_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .byte_value   (stage_byte),
        .byte_address (stage_addr),
        .emit         (emit),
        .result       (result)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = fire && emit;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            desc_reg <= result;
        end
    end

    assign descriptors.valid            = out_valid_reg;
    assign descriptors.start_address    = desc_reg.start_address;
    assign descriptors.length           = desc_reg.length;
    assign descriptors.prefix_group     = desc_reg.prefix_group;
    assign descriptors.opcode           = desc_reg.opcode;
    assign descriptors.displacement     = desc_reg.displacement;
    assign descriptors.has_displacement = desc_reg.has_displacement;
    assign descriptors.immediate        = desc_reg.immediate;
    assign descriptors.immediate_kind   = desc_reg.immediate_kind;
    assign descriptors.branch_target    = desc_reg.branch_target;
    assign descriptors.is_relative      = desc_reg.is_relative;
    assign descriptors.undefined_ed     = desc_reg.undefined_ed;

    `CILD_ASSERT_NEXT(a_stage_held, stage_valid && !advance, stage_valid, "Pending byte lost.")
    `CILD_ASSERT_IMPL(a_len_nonzero, out_valid_reg, desc_reg.length != 8'd0, "Zero length.")
    `CILD_ASSERT_IMPL(a_rel_disp, out_valid_reg && desc_reg.is_relative, desc_reg.has_displacement, "Relative without displacement.")
    `CILD_ASSERT_IMPL(a_undef_grp, out_valid_reg && desc_reg.undefined_ed, desc_reg.prefix_group == cild_pkg::GRP_ED, "Undefined flag outside ED.")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for cpu_instruction_length_decoder_top: drives instruction byte requests with
// random gaps and stalls, and checks every descriptor against a decode predictor.
// Depends on cild_pkg, cild_if and the decoder RTL.
module tb_top;

    localparam int BYTE_BUDGET = 1300;
    localparam int CYCLE_LIMIT = 200000;

    class decode_scoreboard;
        typedef enum logic [2:0] {
            ST_OPCODE, ST_INDEXED, ST_CB, ST_ED, ST_XCB_DISP, ST_XCB_OP, ST_OPERANDS
        } decode_phase_e;

        decode_phase_e   phase;
        logic [1:0]      index_sel;
        logic [7:0]      count;
        logic [1:0]      bytes_left;
        logic [15:0]     first_addr;
        logic [7:0]      op;
        logic [2:0]      grp;
        logic [7:0]      disp;
        logic [15:0]     imm;
        logic [1:0]      imm_kind;
        logic [15:0]     target;
        logic            has_disp;
        logic            rel;
        logic            undef;
        logic            disp_pending;
        cild_pkg::desc_t expected_descs[$];
        int              errors;

        function new();
            clear_instr();
            first_addr = '0;
            errors = 0;
        endfunction

        function void clear_instr();
            phase = ST_OPCODE;
            index_sel = cild_pkg::IDX_NONE;
            count = '0;
            bytes_left = '0;
            op = '0;
            grp = cild_pkg::GRP_NONE;
            disp = '0;
            imm = '0;
            imm_kind = cild_pkg::IMM_NONE;
            target = '0;
            has_disp = 1'b0;
            rel = 1'b0;
            undef = 1'b0;
            disp_pending = 1'b0;
        endfunction

        function bit busy();
            return phase != ST_OPCODE;
        endfunction

        function void finish_instr();
            cild_pkg::desc_t d;
            d.start_address = first_addr;
            d.length = count;
            d.prefix_group = grp;
            d.opcode = op;
            d.displacement = has_disp ? disp : 8'h00;
            d.has_displacement = has_disp;
            d.immediate = imm;
            d.immediate_kind = imm_kind;
            d.branch_target = rel ? target : 16'h0000;
            d.is_relative = rel;
            d.undefined_ed = undef;
            expected_descs.insert(expected_descs.size(), d);
            clear_instr();
        endfunction

        function void decode_main(logic [7:0] b);
            logic [1:0] x;
            logic [2:0] y;
            logic [2:0] z;
            logic [1:0] p;
            logic       q;
            logic       indexed;
            logic       need_disp;
            logic       is_jr;
            logic [1:0] kind;
            x = b[7:6];
            y = b[5:3];
            z = b[2:0];
            p = y[2:1];
            q = y[0];
            indexed = index_sel != cild_pkg::IDX_NONE;
            need_disp = 1'b0;
            is_jr = 1'b0;
            kind = cild_pkg::IMM_NONE;
            op = b;
            grp = indexed ? ((index_sel == cild_pkg::IDX_IX) ? cild_pkg::GRP_DD
                                                              : cild_pkg::GRP_FD)
                          : cild_pkg::GRP_NONE;
            case (x)
                2'd0:
                begin
                    if (z == 3'd0 && y >= 3'd2) is_jr = 1'b1;
                    else if (z == 3'd1 && !q) kind = cild_pkg::IMM_WORD;
                    else if (z == 3'd2 && p >= 2'd2) kind = cild_pkg::IMM_WORD;
                    else if (z == 3'd6) kind = cild_pkg::IMM_BYTE;
                    if (indexed && y == 3'd6 && z >= 3'd4 && z <= 3'd6) need_disp = 1'b1;
                end
                2'd1:
                begin
                    if (indexed && b != 8'h76 && (y == 3'd6 || z == 3'd6)) need_disp = 1'b1;
                end
                2'd2:
                begin
                    if (indexed && z == 3'd6) need_disp = 1'b1;
                end
                default:
                begin
                    if (z == 3'd2 || z == 3'd4) kind = cild_pkg::IMM_WORD;
                    else if (z == 3'd3 && y == 3'd0) kind = cild_pkg::IMM_WORD;
                    else if (z == 3'd3 && (y == 3'd2 || y == 3'd3)) kind = cild_pkg::IMM_BYTE;
                    else if (z == 3'd5 && q && p == 2'd0) kind = cild_pkg::IMM_WORD;
                    else if (z == 3'd6) kind = cild_pkg::IMM_BYTE;
                end
            endcase
            imm_kind = kind;
            bytes_left = kind;
            if (need_disp || is_jr)
            begin
                has_disp = 1'b1;
                disp_pending = 1'b1;
            end
            rel = is_jr;
            if (disp_pending || kind != cild_pkg::IMM_NONE)
                phase = ST_OPERANDS;
            else
                finish_instr();
        endfunction

        function void note_byte(logic [7:0] b, logic [15:0] a);
            logic [1:0] x;
            logic [2:0] y;
            logic [2:0] z;
            x = b[7:6];
            y = b[5:3];
            z = b[2:0];
            if (phase == ST_OPCODE)
            begin
                clear_instr();
                first_addr = a;
            end
            if (count < 8'd255) count = count + 8'd1;
            case (phase)
                ST_OPCODE, ST_INDEXED:
                begin
                    if (b == cild_pkg::PFX_DD)
                    begin
                        index_sel = cild_pkg::IDX_IX;
                        phase = ST_INDEXED;
                    end
                    else if (b == cild_pkg::PFX_FD)
                    begin
                        index_sel = cild_pkg::IDX_IY;
                        phase = ST_INDEXED;
                    end
                    else if (b == cild_pkg::PFX_ED)
                    begin
                        index_sel = cild_pkg::IDX_NONE;
                        phase = ST_ED;
                    end
                    else if (b == cild_pkg::PFX_CB)
                        phase = (index_sel != cild_pkg::IDX_NONE) ? ST_XCB_DISP : ST_CB;
                    else
                        decode_main(b);
                end
                ST_CB:
                begin
                    op = b;
                    grp = cild_pkg::GRP_CB;
                    finish_instr();
                end
                ST_ED:
                begin
                    op = b;
                    grp = cild_pkg::GRP_ED;
                    if (x == 2'd1 && z == 3'd3)
                    begin
                        imm_kind = cild_pkg::IMM_WORD;
                        bytes_left = 2'd2;
                        phase = ST_OPERANDS;
                    end
                    else
                    begin
                        if (x != 2'd1 && !(x == 2'd2 && z <= 3'd3 && y >= 3'd4)) undef = 1'b1;
                        finish_instr();
                    end
                end
                ST_XCB_DISP:
                begin
                    disp = b;
                    has_disp = 1'b1;
                    phase = ST_XCB_OP;
                end
                ST_XCB_OP:
                begin
                    op = b;
                    grp = (index_sel == cild_pkg::IDX_IX) ? cild_pkg::GRP_DDCB
                                                          : cild_pkg::GRP_FDCB;
                    finish_instr();
                end
                default:
                begin
                    if (disp_pending)
                    begin
                        disp = b;
                        disp_pending = 1'b0;
                        target = a + 16'd1 + {{8{b[7]}}, b};
                    end
                    else if (bytes_left != 2'd0)
                    begin
                        if (bytes_left == imm_kind)
                            imm = {8'h00, b};
                        else
                            imm = imm | {b, 8'h00};
                        bytes_left = bytes_left - 2'd1;
                    end
                    if (!disp_pending && bytes_left == 2'd0) finish_instr();
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_desc(cild_pkg::desc_t got);
            cild_pkg::desc_t want;
            if (expected_descs.size() == 0)
            begin
                $error("descriptor with no instruction pending, start_address 0x%0h",
                       got.start_address);
                errors++;
                return;
            end
            want = expected_descs.pop_front();
            check_field("start_address", want.start_address, got.start_address);
            check_field("length", want.length, got.length);
            check_field("prefix_group", want.prefix_group, got.prefix_group);
            check_field("opcode", want.opcode, got.opcode);
            check_field("displacement", want.displacement, got.displacement);
            check_field("has_displacement", want.has_displacement, got.has_displacement);
            check_field("immediate", want.immediate, got.immediate);
            check_field("immediate_kind", want.immediate_kind, got.immediate_kind);
            check_field("branch_target", want.branch_target, got.branch_target);
            check_field("is_relative", want.is_relative, got.is_relative);
            check_field("undefined_ed", want.undefined_ed, got.undefined_ed);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic stall_send;
    logic stall_recv;
    logic [15:0] next_addr;
    int bytes_sent;
    int cycles = 0;
    decode_scoreboard sb = new();

    cild_byte_if byte_ch ();
    cild_desc_if desc_ch ();

    cpu_instruction_length_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_bytes (byte_ch),
        .descriptors (desc_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        logic [15:0] a;
        gap = stall_send ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        if ($urandom_range(0, 31) == 0) next_addr = 16'($urandom);
        a = next_addr;
        next_addr = a + 16'd1;
        byte_ch.valid = 1'b1;
        byte_ch.byte_value = b;
        byte_ch.byte_address = a;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        sb.note_byte(b, a);
        bytes_sent++;
        @(negedge clk);
        byte_ch.valid = 1'b0;
    endtask

    task automatic finish_current();
        while (sb.busy()) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (sb.expected_descs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_prefix_chain(input int n);
        repeat (n) send_byte($urandom_range(0, 1) ? cild_pkg::PFX_DD : cild_pkg::PFX_FD);
        send_byte(8'h00);
        finish_current();
    endtask

    task automatic send_random_instruction();
        int form;
        logic [7:0] b;
        form = $urandom_range(0, 15);
        case (form)
            5: send_byte(cild_pkg::PFX_DD);
            6: send_byte(cild_pkg::PFX_FD);
            7: send_byte(cild_pkg::PFX_CB);
            8, 9, 13:
            begin
                if (form == 13)
                    send_byte($urandom_range(0, 1) ? cild_pkg::PFX_DD : cild_pkg::PFX_FD);
                send_byte(cild_pkg::PFX_ED);
                case ($urandom_range(0, 2))
                    0: b = {2'b01, 3'($urandom_range(0, 7)), 3'd3};
                    1: b = {2'b10, 1'b1, 2'($urandom_range(0, 3)), 1'b0,
                            2'($urandom_range(0, 3))};
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
            end
            10, 11, 14:
            begin
                send_byte((form == 10) ? cild_pkg::PFX_DD : cild_pkg::PFX_FD);
                send_byte(cild_pkg::PFX_CB);
            end
            12:
            begin
                repeat ($urandom_range(2, 4))
                    send_byte($urandom_range(0, 1) ? cild_pkg::PFX_DD : cild_pkg::PFX_FD);
            end
            15:
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                return;
            end
            default: ;
        endcase
        if (sb.phase == decode_scoreboard::ST_OPCODE ||
            sb.phase == decode_scoreboard::ST_INDEXED)
        begin
            if ($urandom_range(0, 3) == 0)
                b = {2'b00, 3'($urandom_range(2, 7)), 3'd0};
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
        finish_current();
    endtask

    initial
    begin : sink_proc
        int gap;
        cild_pkg::desc_t got;
        desc_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = stall_recv ? $urandom_range(0, 4) : 0;
            repeat (gap)
            begin
                desc_ch.ready = 1'b0;
                @(negedge clk);
            end
            desc_ch.ready = 1'b1;
            @(posedge clk);
            while (!desc_ch.valid) @(posedge clk);
            got.start_address = desc_ch.start_address;
            got.length = desc_ch.length;
            got.prefix_group = desc_ch.prefix_group;
            got.opcode = desc_ch.opcode;
            got.displacement = desc_ch.displacement;
            got.has_displacement = desc_ch.has_displacement;
            got.immediate = desc_ch.immediate;
            got.immediate_kind = desc_ch.immediate_kind;
            got.branch_target = desc_ch.branch_target;
            got.is_relative = desc_ch.is_relative;
            got.undefined_ed = desc_ch.undefined_ed;
            sb.check_desc(got);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int mark;
        rst_n = 1'b0;
        bytes_sent = 0;
        stall_send = 1'b0;
        stall_recv = 1'b0;
        next_addr = 16'h0000;
        byte_ch.valid = 1'b0;
        byte_ch.byte_value = '0;
        byte_ch.byte_address = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_byte(8'h00);
        next_addr = 16'hFFFD;
        send_byte(8'h18); send_byte(8'h7F);
        send_byte(8'h10); send_byte(8'h80);
        send_byte(cild_pkg::PFX_DD); send_byte(8'h36); send_byte(8'h80); send_byte(8'hFF);
        send_byte(cild_pkg::PFX_FD); send_byte(cild_pkg::PFX_CB);
        send_byte(8'h7F); send_byte(8'hFE);
        send_byte(cild_pkg::PFX_CB); send_byte(8'hFF);
        send_byte(cild_pkg::PFX_ED); send_byte(8'h43);
        next_addr = 16'h8000;
        send_byte(8'h34); send_byte(8'h12);
        send_byte(cild_pkg::PFX_ED); send_byte(8'hB0);
        send_byte(cild_pkg::PFX_ED); send_byte(8'h00);
        send_byte(cild_pkg::PFX_ED); send_byte(8'hFF);
        send_byte(cild_pkg::PFX_ED); send_byte(8'h7F);
        send_byte(cild_pkg::PFX_DD); send_byte(cild_pkg::PFX_ED); send_byte(8'h4B);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(cild_pkg::PFX_DD); send_byte(cild_pkg::PFX_FD); send_byte(8'h21);
        send_byte(8'hFF); send_byte(8'h00);
        send_byte(cild_pkg::PFX_DD); send_byte(8'h76);
        wait_drained();

        mark = 0;
        while (bytes_sent < BYTE_BUDGET)
        begin
            if (bytes_sent >= mark)
            begin
                mark = bytes_sent + 150;
                stall_send = 1'($urandom_range(0, 1));
                stall_recv = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 2) == 0) wait_drained();
            end
            if (bytes_sent >= 400 && bytes_sent < 420)
                send_prefix_chain($urandom_range(255, 262));
            else if (bytes_sent >= 900 && bytes_sent < 920)
                send_prefix_chain(254);
            else
                send_random_instruction();
        end
        finish_current();
        byte_ch.valid = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* cpu_instruction_length_decoder_top.f */
+incdir+sv
sv/cild_pkg.sv
sv/cild_if.sv
sv/cild_in_stage.sv
sv/cild_step.sv
sv/cpu_instruction_length_decoder_top.sv
sim/tb_top.sv
